@@ rtl/rva_pkg.sv @@
// Package: constants and tables for the axis-angle vector rotation block.
package rva_pkg;
  localparam int CordicStagesDefault = 16;
  localparam int VecDim = 3;
  localparam int AtanEntries = 24;
  localparam logic signed [33:0] GainInv = 34'sd652032874;

  function automatic logic signed [33:0] atan_val(input int i);
    logic signed [33:0] r;
    r = '0;
    case (i)
      0: r = 34'sd536870912;
      1: r = 34'sd316933406;
      2: r = 34'sd167458907;
      3: r = 34'sd85004756;
      4: r = 34'sd42667331;
      5: r = 34'sd21354465;
      6: r = 34'sd10679838;
      7: r = 34'sd5340245;
      8: r = 34'sd2670163;
      9: r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } geo_t;
endpackage

@@ rtl/rva_cordic.sv @@
// Unrolled CORDIC pipeline: binary angle to rounded Q4.14 cos and sin.
module rva_cordic #(
  parameter int CORDIC_STAGES = rva_pkg::CordicStagesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [15:0]         angle,
  input  rva_pkg::geo_t       geo_in,
  output logic                out_valid,
  output logic signed [17:0]  cos_q,
  output logic signed [17:0]  sin_q,
  output rva_pkg::geo_t       geo_out
);
  import rva_pkg::*;

  localparam int N = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

  logic               vld  [N+1];
  logic               flp  [N+1];
  logic signed [33:0] xs   [N+1];
  logic signed [33:0] ys   [N+1];
  logic signed [33:0] zs   [N+1];
  geo_t               gs   [N+1];
  logic signed [16:0] a_fold;
  logic               f_fold;
  logic signed [33:0] x_rnd;
  logic signed [33:0] y_rnd;
  logic signed [17:0] c_pre;
  logic signed [17:0] s_pre;

  always_comb begin
    a_fold = 17'(signed'(angle));
    f_fold = 1'b0;
    if (a_fold >= 17'sd16384) begin
      a_fold = a_fold - 17'sd32768;
      f_fold = 1'b1;
    end else if (a_fold < -17'sd16384) begin
      a_fold = a_fold + 17'sd32768;
      f_fold = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      flp[0] <= f_fold;
      xs[0]  <= GainInv;
      ys[0]  <= '0;
      zs[0]  <= {a_fold[16], a_fold, 16'b0};
      gs[0]  <= geo_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        flp[i+1] <= flp[i];
        gs[i+1]  <= gs[i];
        if (!zs[i][33]) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_val(i);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_val(i);
        end
      end
    end
  end

  always_comb begin
    x_rnd = (xs[N] + 34'sd32768) >>> 16;
    y_rnd = (ys[N] + 34'sd32768) >>> 16;
    c_pre = flp[N] ? -x_rnd[17:0] : x_rnd[17:0];
    s_pre = flp[N] ? -y_rnd[17:0] : y_rnd[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
    if (en) begin
      cos_q   <= c_pre;
      sin_q   <= s_pre;
      geo_out <= gs[N];
    end
  end
endmodule

@@ rtl/rva_matvec.sv @@
// Rodrigues matrix build and matrix-vector product, pipelined, with saturation.
module rva_matvec (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [17:0] cos_q,
  input  logic signed [17:0] sin_q,
  input  rva_pkg::geo_t      geo_in,
  output logic               out_valid,
  output logic [15:0]        res_x,
  output logic [15:0]        res_y,
  output logic [15:0]        res_z,
  output logic               res_sat
);
  import rva_pkg::*;

  // stage A: t*ai, c*16384, s*ai
  logic               va;
  logic signed [34:0] ta   [VecDim];
  logic signed [34:0] sa   [VecDim];
  logic signed [33:0] cd;
  logic signed [15:0] axa  [VecDim];
  logic signed [15:0] vva  [VecDim];
  // stage B: matrix
  logic               vb;
  logic signed [35:0] mm   [VecDim][VecDim];
  logic signed [15:0] vvb  [VecDim];
  // stage C: products
  logic               vc;
  logic signed [51:0] pp   [VecDim][VecDim];
  // stage D: sum and round
  logic               vd;
  logic signed [53:0] rr   [VecDim];
  logic signed [17:0] t_w;
  logic signed [15:0] axg  [VecDim];
  logic signed [15:0] vvg  [VecDim];
  logic signed [35:0] mb   [VecDim][VecDim];
  logic signed [50:0] tp   [VecDim][VecDim];
  logic [15:0]        oc   [VecDim];
  logic               ocs  [VecDim];

  assign axg[0] = geo_in.ax;
  assign axg[1] = geo_in.ay;
  assign axg[2] = geo_in.az;
  assign vvg[0] = geo_in.vx;
  assign vvg[1] = geo_in.vy;
  assign vvg[2] = geo_in.vz;
  assign t_w = 18'sd16384 - cos_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else if (en) begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
    if (en) begin
      cd <= 34'(cos_q) <<< 14;
      for (int i = 0; i < VecDim; i++) begin
        ta[i]  <= 35'(t_w) * 35'(axg[i]);
        sa[i]  <= 35'(sin_q) * 35'(axg[i]);
        axa[i] <= axg[i];
        vva[i] <= vvg[i];
        vvb[i] <= vva[i];
      end
      mm <= mb;
      for (int i = 0; i < VecDim; i++) begin
        for (int k = 0; k < VecDim; k++) begin
          pp[i][k] <= 52'(mm[i][k]) * 52'(vvb[k]);
        end
        rr[i] <= (54'(pp[i][0]) + 54'(pp[i][1]) + 54'(pp[i][2]) + 54'sd134217728) >>> 28;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VecDim; i++) begin
      for (int k = 0; k < VecDim; k++) begin
        tp[i][k] = 51'(ta[i]) * 51'(axa[k]);
        mb[i][k] = 36'((tp[i][k] + 51'sd8192) >>> 14);
      end
      mb[i][i] = mb[i][i] + 36'(cd);
    end
    mb[0][1] = mb[0][1] - 36'(sa[2]);
    mb[0][2] = mb[0][2] + 36'(sa[1]);
    mb[1][0] = mb[1][0] + 36'(sa[2]);
    mb[1][2] = mb[1][2] - 36'(sa[0]);
    mb[2][0] = mb[2][0] - 36'(sa[1]);
    mb[2][1] = mb[2][1] + 36'(sa[0]);
  end

  always_comb begin
    for (int i = 0; i < VecDim; i++) begin
      ocs[i] = 1'b1;
      if (rr[i] > 54'sd32767) begin
        oc[i] = 16'h7FFF;
      end else if (rr[i] < -54'sd32768) begin
        oc[i] = 16'h8000;
      end else begin
        oc[i]  = rr[i][15:0];
        ocs[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vd;
    end
    if (en) begin
      res_x   <= oc[0];
      res_y   <= oc[1];
      res_z   <= oc[2];
      res_sat <= ocs[0] | ocs[1] | ocs[2];
    end
  end
endmodule

@@ rtl/rotate_vector_about_axis.sv @@
// Top level: rotates a Q4.12 vector about a unit axis by a binary angle.
// Usage:
//   Input stream s_axis: one beat carries vector, axis and angle.
//   Output stream m_axis: one beat carries the rotated vector and a clip flag.
//   Each input beat gives exactly one output beat, in order.
// Pipeline: one fold stage, CORDIC_STAGES rotation stages (capped at
//   AtanEntries), one rounding stage, four matrix/product stages and one
//   saturation stage lie between an input beat and its output beat.
// Throughput: one beat per cycle when not stalled; all stages advance on one
//   enable, so the unrolled CORDIC and the 3x3 multiplier array set the rate.
// Stall: when m_axis_tready is low and the output holds a beat, the pipeline
//   freezes and s_axis_tready drops; nothing is lost or repeated.
// Reset: rst (synchronous, active high) clears all valid bits; the data
//   registers are not reset.
module rotate_vector_about_axis #(
  parameter int CORDIC_STAGES = rva_pkg::CordicStagesDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [47:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);
  import rva_pkg::*;

  logic               en;
  logic               cv;
  logic signed [17:0] cq;
  logic signed [17:0] sq;
  geo_t               gi;
  geo_t               go;
  logic [15:0]        rx;
  logic [15:0]        ry;
  logic [15:0]        rz;

  assign en = m_axis_tready | ~m_axis_tvalid;
  assign s_axis_tready = en;
  assign gi.vx = s_axis_tdata[15:0];
  assign gi.vy = s_axis_tdata[31:16];
  assign gi.vz = s_axis_tdata[47:32];
  assign gi.ax = s_axis_tdata[63:48];
  assign gi.ay = s_axis_tdata[79:64];
  assign gi.az = s_axis_tdata[95:80];
  assign m_axis_tdata = {rz, ry, rx};

  rva_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .en,
    .in_valid(s_axis_tvalid),
    .angle(s_axis_tdata[111:96]),
    .geo_in(gi),
    .out_valid(cv),
    .cos_q(cq),
    .sin_q(sq),
    .geo_out(go)
  );

  rva_matvec u_matvec (
    .clk, .rst, .en,
    .in_valid(cv),
    .cos_q(cq),
    .sin_q(sq),
    .geo_in(go),
    .out_valid(m_axis_tvalid),
    .res_x(rx),
    .res_y(ry),
    .res_z(rz),
    .res_sat(m_axis_tuser)
  );
endmodule
